// ===== design/ewf_pkg.sv =====
// Shared constants, register map and CRC helper for the Ethernet to 802.11 framer.
// No dependencies; used by ethernet_to_wifi_data_framer.
`timescale 1ns / 1ps
`default_nettype none

package ewf_pkg;

    // Frame geometry
    localparam logic [11:0] MAX_FRAME_BYTES = 12'd1500;
    localparam logic [11:0] ETH_HDR_BYTES   = 12'd14;
    localparam logic [11:0] ETH_ADDR_BYTES  = 12'd6;
    localparam int unsigned WLAN_HDR_BYTES  = 24;
    localparam int unsigned HDR_IDX_W       = 5;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(WLAN_HDR_BYTES - 1);
    localparam logic [HDR_IDX_W-1:0] FCS_LAST_IDX = HDR_IDX_W'(3);
    localparam logic [15:0] FRAME_CTRL      = 16'h0008;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Frame status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    // Register map (index = paddr[4:3])
    localparam int unsigned PADDR_W = 5;
    localparam logic [1:0] REG_ADDR_MODE = 2'd0;
    localparam logic [1:0] REG_SRC_ADDR  = 2'd1;
    localparam logic [1:0] REG_DST_ADDR  = 2'd2;
    localparam logic [1:0] REG_BSS_ADDR  = 2'd3;

    // One byte through the reflected CRC-32, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/ethernet_to_wifi_data_framer.sv =====
// Ethernet to 802.11 data framer: strips the Ethernet header, prepends a data header, appends FCS.
// Depends on ewf_pkg (constants, register map, CRC-32 byte update).
`timescale 1ns / 1ps
`default_nettype none

// Takes an Ethernet frame one byte per word and emits the matching 802.11 data frame.
// Payload bytes pass at one word per cycle while the output is not stalled. The first payload
// byte (or the fourteenth byte when it ends the frame) holds the input while the header goes
// out, and the last byte holds it while the FCS goes out. The rate is set by the single output
// word register, which issues one byte per cycle unless m_ready stalls it. Short frames (under
// 14 bytes) give only one marker word with out_last set and a non-zero frame_status; frames
// over MAX_FRAME_BYTES end in such a marker word in place of the FCS. The sequence number only
// advances on frames that end with an FCS. Addresses are sampled as the header is sent.
module ethernet_to_wifi_data_framer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input byte stream
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_in_byte,
    input  wire logic                          s_in_last,
    // Output byte stream
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_out_last,
    output logic [1:0]                         m_frame_status,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ewf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    // Phase of the word being produced for the held input byte
    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_FCS  = 3'd3;
    localparam logic [2:0] PH_MARK = 3'd4;

    // Configuration registers
    logic        addr_mode_reg;
    logic [47:0] src_addr_reg;
    logic [47:0] dst_addr_reg;
    logic [47:0] bss_addr_reg;

    // Frame state
    logic [11:0] pos_reg,  pos_next;
    logic [11:0] seq_reg,  seq_next;
    logic [31:0] crc_reg,  crc_next;
    logic [47:0] cap_dst_reg, cap_dst_next;
    logic [47:0] cap_src_reg, cap_src_next;
    logic [1:0]  err_reg,  err_next;

    // Input holding register
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg;
    logic        hold_last_reg;

    // Word sequencer
    logic                           started_reg, started_next;
    logic [2:0]                     phase_reg,   phase_next;
    logic [ewf_pkg::HDR_IDX_W-1:0]  idx_reg,     idx_next;

    // Output word register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg;
    logic        m_last_reg;
    logic [1:0]  m_status_reg;

    logic        err_path;
    logic        data_en;
    logic [2:0]  first_phase;
    logic [2:0]  cur_phase;
    logic        out_free;
    logic        emit;
    logic        final_step;
    logic        retire;
    logic        in_take;
    logic [7:0]  word_byte;
    logic        word_last;
    logic [1:0]  word_status;
    logic [47:0] a1;
    logic [47:0] a2;
    logic [31:0] fcs;
    logic [7:0]  hdr_bytes [ewf_pkg::WLAN_HDR_BYTES];
    logic [7:0]  fcs_bytes [4];
    logic        cfg_wr;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[4:3])
            ewf_pkg::REG_ADDR_MODE: prdata = {63'd0, addr_mode_reg};
            ewf_pkg::REG_SRC_ADDR:  prdata = {16'd0, src_addr_reg};
            ewf_pkg::REG_DST_ADDR:  prdata = {16'd0, dst_addr_reg};
            ewf_pkg::REG_BSS_ADDR:  prdata = {16'd0, bss_addr_reg};
            default:                prdata = 64'd0;
        endcase
    end

    // Header bytes, sampled as they go out
    assign a1 = addr_mode_reg ? cap_dst_reg : dst_addr_reg;
    assign a2 = addr_mode_reg ? cap_src_reg : src_addr_reg;

    always_comb begin
        hdr_bytes[0] = ewf_pkg::FRAME_CTRL[7:0];
        hdr_bytes[1] = ewf_pkg::FRAME_CTRL[15:8];
        hdr_bytes[2] = 8'd0;
        hdr_bytes[3] = 8'd0;
        for (int i = 0; i < 6; i++) begin
            hdr_bytes[4 + i]  = a1[8*(5-i) +: 8];
            hdr_bytes[10 + i] = a2[8*(5-i) +: 8];
            hdr_bytes[16 + i] = bss_addr_reg[8*(5-i) +: 8];
        end
        hdr_bytes[22] = {seq_reg[3:0], 4'h0};
        hdr_bytes[23] = seq_reg[11:4];
    end

    // FCS, least significant byte first
    assign fcs = ~crc_reg;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fcs_bytes[i] = fcs[8*i +: 8];
        end
    end

    // Decide what the held byte produces
    assign err_path = (err_reg != ewf_pkg::STATUS_OK) || (pos_reg >= ewf_pkg::MAX_FRAME_BYTES);
    assign data_en  = pos_reg >= ewf_pkg::ETH_HDR_BYTES;

    always_comb begin
        if (err_path) begin
            first_phase = hold_last_reg ? PH_MARK : PH_NONE;
        end else if (pos_reg == ewf_pkg::ETH_HDR_BYTES) begin
            first_phase = PH_HDR;
        end else if (data_en) begin
            first_phase = PH_DATA;
        end else if (hold_last_reg && pos_reg == ewf_pkg::ETH_HDR_BYTES - 12'd1) begin
            first_phase = PH_HDR;
        end else if (hold_last_reg) begin
            first_phase = PH_MARK;
        end else begin
            first_phase = PH_NONE;
        end
    end

    assign cur_phase = started_reg ? phase_reg : first_phase;

    // Word handshake
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = hold_valid_reg && (cur_phase != PH_NONE) && out_free;

    always_comb begin
        case (cur_phase)
            PH_DATA: final_step = !hold_last_reg;
            PH_FCS:  final_step = idx_reg == ewf_pkg::FCS_LAST_IDX;
            PH_MARK: final_step = 1'b1;
            default: final_step = 1'b0;
        endcase
    end

    assign retire  = hold_valid_reg && ((cur_phase == PH_NONE) || (emit && final_step));
    assign s_ready = !hold_valid_reg || retire;
    assign in_take = s_valid && s_ready;

    // Word contents
    always_comb begin
        word_last   = 1'b0;
        word_status = ewf_pkg::STATUS_OK;
        case (cur_phase)
            PH_HDR:  word_byte = hdr_bytes[idx_reg];
            PH_DATA: word_byte = hold_byte_reg;
            PH_FCS: begin
                word_byte = fcs_bytes[idx_reg[1:0]];
                word_last = idx_reg == ewf_pkg::FCS_LAST_IDX;
            end
            PH_MARK: begin
                word_byte   = 8'd0;
                word_last   = 1'b1;
                word_status = err_path ? ewf_pkg::STATUS_LONG : ewf_pkg::STATUS_SHORT;
            end
            default: word_byte = 8'd0;
        endcase
    end

    // Sequencer and frame state
    always_comb begin
        started_next    = started_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        crc_next        = crc_reg;
        pos_next        = pos_reg;
        seq_next        = seq_reg;
        err_next        = err_reg;
        cap_dst_next    = cap_dst_reg;
        cap_src_next    = cap_src_reg;
        hold_valid_next = hold_valid_reg;
        m_valid_next    = m_valid_reg;

        // CRC covers header and payload bytes
        if (emit && (cur_phase == PH_HDR || cur_phase == PH_DATA)) begin
            crc_next = ewf_pkg::crc32_byte(crc_reg, word_byte);
        end

        // Step through the words of the held byte
        if (emit && !final_step) begin
            started_next = 1'b1;
            case (cur_phase)
                PH_HDR: begin
                    if (idx_reg == ewf_pkg::HDR_LAST_IDX) begin
                        phase_next = data_en ? PH_DATA : PH_FCS;
                        idx_next   = '0;
                    end else begin
                        phase_next = PH_HDR;
                        idx_next   = idx_reg + ewf_pkg::HDR_IDX_W'(1);
                    end
                end
                PH_DATA: begin
                    phase_next = PH_FCS;
                    idx_next   = '0;
                end
                PH_FCS: begin
                    phase_next = PH_FCS;
                    idx_next   = idx_reg + ewf_pkg::HDR_IDX_W'(1);
                end
                default: begin
                    phase_next = PH_NONE;
                    idx_next   = '0;
                end
            endcase
        end

        // Byte done: update the frame state
        if (retire) begin
            started_next = 1'b0;
            idx_next     = '0;
            if (err_path) begin
                err_next = ewf_pkg::STATUS_LONG;
            end else begin
                if (pos_reg < ewf_pkg::ETH_ADDR_BYTES) begin
                    cap_dst_next = {cap_dst_reg[39:0], hold_byte_reg};
                end else if (pos_reg < ewf_pkg::ETH_ADDR_BYTES + ewf_pkg::ETH_ADDR_BYTES) begin
                    cap_src_next = {cap_src_reg[39:0], hold_byte_reg};
                end
                pos_next = pos_reg + 12'd1;
                if (hold_last_reg && pos_reg >= ewf_pkg::ETH_HDR_BYTES - 12'd1) begin
                    seq_next = seq_reg + 12'd1;
                end
            end
            if (hold_last_reg) begin
                pos_next = '0;
                crc_next = ewf_pkg::CRC_INIT;
                err_next = ewf_pkg::STATUS_OK;
            end
        end

        // Holding register
        if (in_take) begin
            hold_valid_next = 1'b1;
        end else if (retire) begin
            hold_valid_next = 1'b0;
        end

        // Output word register
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_mode_reg  <= 1'b0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            bss_addr_reg   <= '0;
            pos_reg        <= '0;
            seq_reg        <= '0;
            crc_reg        <= ewf_pkg::CRC_INIT;
            cap_dst_reg    <= '0;
            cap_src_reg    <= '0;
            err_reg        <= ewf_pkg::STATUS_OK;
            hold_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
            phase_reg      <= PH_NONE;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:3])
                    ewf_pkg::REG_ADDR_MODE: addr_mode_reg <= pwdata[0];
                    ewf_pkg::REG_SRC_ADDR:  src_addr_reg  <= pwdata[47:0];
                    ewf_pkg::REG_DST_ADDR:  dst_addr_reg  <= pwdata[47:0];
                    ewf_pkg::REG_BSS_ADDR:  bss_addr_reg  <= pwdata[47:0];
                    default: ;
                endcase
            end
            pos_reg        <= pos_next;
            seq_reg        <= seq_next;
            crc_reg        <= crc_next;
            cap_dst_reg    <= cap_dst_next;
            cap_src_reg    <= cap_src_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
            started_reg    <= started_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            hold_byte_reg <= s_in_byte;
            hold_last_reg <= s_in_last;
        end
        if (emit) begin
            m_byte_reg   <= word_byte;
            m_last_reg   <= word_last;
            m_status_reg <= word_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_out_last     = m_last_reg;
    assign m_frame_status = m_status_reg;

endmodule

`default_nettype wire
